// ===== src/bpfm_pkg.sv =====
// Types and codes shared by the buffer pool frame manager and its checker.
// No dependencies.
`default_nettype none
package bpfm_pkg;

  // Commands carried on command_i
  localparam logic [1:0] CMD_GET   = 2'd0;
  localparam logic [1:0] CMD_REL   = 2'd1;
  localparam logic [1:0] CMD_DIRTY = 2'd2;
  localparam logic [1:0] CMD_BAD   = 2'd3;  // unused encoding, answered as not resident

  // Result status codes
  localparam logic [2:0] ST_DONE   = 3'd0;
  localparam logic [2:0] ST_MISS   = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_ABSENT = 3'd3;
  localparam logic [2:0] ST_UNDER  = 3'd4;

  localparam logic [15:0] REFS_MAX = 16'hFFFF;

  // One frame table entry
  typedef struct packed {
    logic [31:0] page;
    logic        resident;
    logic        dirty;
    logic [15:0] refs;
    logic [63:0] stamp;
  } frame_ent_t;

endpackage
`default_nettype wire

// ===== src/buffer_pool_frame_manager.sv =====
// Buffer pool frame manager: frame table held in one synchronous RAM.
// Depends on bpfm_pkg.
// Each transaction is scanned over every frame through the RAM's registered read,
// then written back in a write state that waits while the output is stalled.
// One transaction at a time: input is taken only in idle, after the write-back.
// Reset: control clears at once; a clearing pass then zeroes the table,
// with in_stall_o high throughout.
`default_nettype none
module buffer_pool_frame_manager #(
  parameter int FRAMES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] page_id_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [5:0]       frame_o,
  output logic             writeback_o,
  output logic [31:0]      writeback_page_id_o
);
  import bpfm_pkg::*;

  localparam int IW = $clog2(FRAMES);
  localparam logic [IW:0] CNT_END = (IW+1)'(FRAMES);

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;

  logic [2:0]    state_q;
  logic [IW:0]   cnt_q;       // clear pointer, then scan read pointer
  logic          pend_q;      // read data valid this cycle
  logic [IW-1:0] pend_idx_q;
  logic [63:0]   clock_q;     // access clock

  // Transaction being worked on
  logic [1:0]  cmd_q;
  logic [31:0] pid_q;

  // Lookup result
  logic          hit_q;
  logic [IW-1:0] hit_idx_q;
  frame_ent_t    hit_ent_q;

  // Victim candidate
  logic          vic_q;
  logic [IW-1:0] vic_idx_q;
  logic [63:0]   vic_stamp_q;
  logic          vic_wb_q;
  logic [31:0]   vic_page_q;

  // Output register
  logic        out_valid_q;
  logic [2:0]  status_q;
  logic [5:0]  frame_q;
  logic        wb_q;
  logic [31:0] wb_pid_q;

  // Frame table RAM
  frame_ent_t mem_q [FRAMES];
  frame_ent_t rdata_q;
  logic       we;
  logic [IW-1:0] waddr;
  frame_ent_t wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[cnt_q[IW-1:0]];
  end

  // Write-back decision
  logic        can_out;
  logic        bump;
  logic [2:0]  res_status;
  logic [IW-1:0] res_idx;
  logic        res_wb;
  logic [63:0] next_clock;

  assign can_out    = !out_valid_q || !out_stall_i;
  assign next_clock = clock_q + 64'd1;

  always_comb begin
    we         = 1'b0;
    waddr      = hit_idx_q;
    wdata      = hit_ent_q;
    bump       = 1'b0;
    res_status = ST_ABSENT;
    res_idx    = '0;
    res_wb     = 1'b0;
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q[IW-1:0];
        wdata = '0;
      end
      S_WRITE: begin
        case (cmd_q)
          CMD_GET: begin
            if (hit_q) begin
              if (hit_ent_q.refs != REFS_MAX) begin
                wdata.refs = hit_ent_q.refs + 16'd1;
              end
              wdata.stamp = next_clock;
              we          = can_out;
              bump        = 1'b1;
              res_status  = ST_DONE;
              res_idx     = hit_idx_q;
            end else if (vic_q) begin
              waddr          = vic_idx_q;
              wdata.page     = pid_q;
              wdata.resident = 1'b1;
              wdata.dirty    = 1'b0;
              wdata.refs     = 16'd1;
              wdata.stamp    = next_clock;
              we             = can_out;
              bump           = 1'b1;
              res_status     = ST_MISS;
              res_idx        = vic_idx_q;
              res_wb         = vic_wb_q;
            end else begin
              res_status = ST_FULL;
            end
          end
          CMD_REL: begin
            if (hit_q) begin
              res_idx = hit_idx_q;
              if (hit_ent_q.refs == 16'd0) begin
                res_status = ST_UNDER;
              end else begin
                wdata.refs = hit_ent_q.refs - 16'd1;
                we         = can_out;
                res_status = ST_DONE;
              end
            end
          end
          CMD_DIRTY: begin
            if (hit_q) begin
              wdata.dirty = 1'b1;
              we          = can_out;
              res_status  = ST_DONE;
              res_idx     = hit_idx_q;
            end
          end
          default: begin
            res_status = ST_ABSENT;
          end
        endcase
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      vic_q       <= 1'b0;
      clock_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (state_q == S_WRITE && can_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (cnt_q == CNT_END - 1'b1) begin
            state_q <= S_IDLE;
          end
          cnt_q <= cnt_q + 1'b1;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_SCAN;
            cnt_q   <= '0;
            pend_q  <= 1'b0;
            hit_q   <= 1'b0;
            vic_q   <= 1'b0;
          end
        end
        S_SCAN: begin
          if (cnt_q != CNT_END) begin
            cnt_q  <= cnt_q + 1'b1;
            pend_q <= 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              state_q <= S_WRITE;
            end
          end
          if (pend_q) begin
            if (!hit_q && rdata_q.resident && rdata_q.page == pid_q) begin
              hit_q <= 1'b1;
            end
            if (rdata_q.refs == 16'd0 && (!vic_q || rdata_q.stamp < vic_stamp_q)) begin
              vic_q <= 1'b1;
            end
          end
        end
        S_WRITE: begin
          if (can_out) begin
            if (bump) begin
              clock_q <= next_clock;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      cmd_q <= command_i;
      pid_q <= page_id_i;
    end
    if (state_q == S_SCAN) begin
      pend_idx_q <= cnt_q[IW-1:0];
    end
    if (state_q == S_SCAN && pend_q) begin
      if (!hit_q && rdata_q.resident && rdata_q.page == pid_q) begin
        hit_idx_q <= pend_idx_q;
        hit_ent_q <= rdata_q;
      end
      if (rdata_q.refs == 16'd0 && (!vic_q || rdata_q.stamp < vic_stamp_q)) begin
        vic_idx_q   <= pend_idx_q;
        vic_stamp_q <= rdata_q.stamp;
        vic_wb_q    <= rdata_q.resident & rdata_q.dirty;
        vic_page_q  <= rdata_q.page;
      end
    end
    if (state_q == S_WRITE && can_out) begin
      status_q <= res_status;
      frame_q  <= 6'(res_idx);
      wb_q     <= res_wb;
      wb_pid_q <= res_wb ? vic_page_q : 32'd0;
    end
  end

  assign in_stall_o          = (state_q != S_IDLE);
  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign frame_o             = frame_q;
  assign writeback_o         = wb_q;
  assign writeback_page_id_o = wb_pid_q;

endmodule
`default_nettype wire

// ===== src/bpfm_checker.sv =====
// Port-level checker for the buffer pool frame manager, bound to the top level.
// Depends on bpfm_pkg.
`default_nettype none
module bpfm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  status_o,
  input wire logic [5:0]  frame_o,
  input wire logic        writeback_o
);
  import bpfm_pkg::*;

  logic in_acc, out_acc;
  logic [1:0] open_q;   // transactions in flight

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // one result may wait in the output register while the next is worked on
  a_two_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= 2'd2) else $error("more than two transactions in flight");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> open_q == 2'd1) else $error("result without request");

  a_wb_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && writeback_o |-> status_o == ST_MISS)
    else $error("writeback without miss");

  a_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_ABSENT) |-> frame_o == 6'd0)
    else $error("frame set on failed request");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(frame_o))
    else $error("stalled result changed");

endmodule

bind buffer_pool_frame_manager bpfm_checker u_bpfm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .frame_o     (frame_o),
  .writeback_o (writeback_o)
);
`default_nettype wire
